[hw/rtl/uce_pkg.sv]
package uce_pkg;

    localparam int HALF_W    = 16;
    localparam int LANES     = 6;
    localparam int COUNT_W   = 17;
    localparam int S_TDATA_W = 152;
    localparam int M_TDATA_W = 16;

    // Lane assignment: what each lane folds on the way in.
    localparam int LANE_SRC   = 0;  // source address halves
    localparam int LANE_DST   = 1;  // destination address halves
    localparam int LANE_PROTO = 2;  // protocol number and header checksum field
    localparam int LANE_PORTS = 3;  // source and destination ports
    localparam int LANE_DATA  = 4;  // payload word halves
    localparam int LANE_LEN   = 5;  // UDP length, counted twice

    // Slave tdata field offsets, lowest bit first.
    localparam int OFS_DATA         = 0;
    localparam int OFS_COUNT        = 32;
    localparam int OFS_SRC_ADDR     = 35;
    localparam int OFS_DST_ADDR     = 67;
    localparam int OFS_SRC_UDP_PORT = 99;
    localparam int OFS_DST_UDP_PORT = 115;
    localparam int OFS_HDR_CK       = 131;

    localparam logic [HALF_W-1:0]  UDP_PROTOCOL  = 16'd17;
    localparam logic [HALF_W-1:0]  UDP_HDR_BYTES = 16'd8;
    localparam logic [2:0]         WORD_BYTES    = 3'd4;

    typedef logic [HALF_W-1:0] t_half;

    typedef struct packed {
        logic last;
        logic start;
    } t_ctrl;

    // Ones' complement add with end-around carry.
    function automatic t_half eac_add(input t_half a, input t_half b);
        logic [HALF_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[HALF_W-1:0] + t_half'(s[HALF_W]);
    endfunction

endpackage

[hw/rtl/uce_lane.sv]
module uce_lane (
    input  logic          i_clk,
    input  logic          i_en,
    input  uce_pkg::t_half i_a,
    input  uce_pkg::t_half i_b,
    output uce_pkg::t_half o_sum
);

    uce_pkg::t_half r_sum;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum <= uce_pkg::eac_add(i_a, i_b);
        end
    end

    assign o_sum = r_sum;

endmodule

[hw/rtl/uce_merge.sv]
module uce_merge (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_a_valid,
    input  uce_pkg::t_ctrl i_a_ctrl,
    input  uce_pkg::t_half i_part [uce_pkg::LANES],
    output logic           o_a_take,
    output logic           o_valid,
    input  logic           i_ready,
    output uce_pkg::t_half o_checksum,
    output logic           o_is_zero
);

    logic           r_b_valid;
    uce_pkg::t_ctrl r_b_ctrl;
    uce_pkg::t_half r_b0;
    uce_pkg::t_half r_b1;
    uce_pkg::t_half r_acc;
    logic           r_out_valid;
    uce_pkg::t_half r_out_ck;
    logic           r_out_zero;

    logic           out_free;
    logic           b_move;
    uce_pkg::t_half acc_base;
    uce_pkg::t_half n_acc;

    assign out_free = !r_out_valid || i_ready;
    // Only a last word needs the output register to be free.
    assign b_move   = r_b_valid && (!r_b_ctrl.last || out_free);
    assign o_a_take = i_a_valid && (!r_b_valid || b_move);

    assign acc_base = r_b_ctrl.start ? '0 : r_acc;
    assign n_acc    = uce_pkg::eac_add(uce_pkg::eac_add(acc_base, r_b0), r_b1);

    always_ff @(posedge i_clk) begin
        if (o_a_take) begin
            r_b0 <= uce_pkg::eac_add(
                uce_pkg::eac_add(i_part[uce_pkg::LANE_SRC], i_part[uce_pkg::LANE_DST]),
                uce_pkg::eac_add(i_part[uce_pkg::LANE_PROTO], i_part[uce_pkg::LANE_PORTS]));
            r_b1 <= uce_pkg::eac_add(i_part[uce_pkg::LANE_DATA], i_part[uce_pkg::LANE_LEN]);
        end
        if (b_move && r_b_ctrl.last) begin
            r_out_ck   <= ~n_acc;
            r_out_zero <= (n_acc == 16'hffff);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_b_ctrl    <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_a_take) begin
                r_b_valid <= 1'b1;
                r_b_ctrl  <= i_a_ctrl;
            end else if (b_move) begin
                r_b_valid <= 1'b0;
            end
            if (b_move) begin
                r_acc <= n_acc;
            end
            if (b_move && r_b_ctrl.last) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid    = r_out_valid;
    assign o_checksum = r_out_ck;
    assign o_is_zero  = r_out_zero;

endmodule

[hw/rtl/udp_ipv4_checksum_engine.sv]
// Pipeline: a last word passes the lane registers, the merge register and the output
//   register before its result is presented; the accumulator update is a registered loop.
// Throughput: one word per cycle while no held result stalls the input.
// Reset: synchronous, active low; sets the packet-start flag and clears the pipeline valids,
//   the latched mode, byte count and running sum. Payload registers are not reset.
module udp_ipv4_checksum_engine (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // tdata from bit 0: data_word[31:0], byte_count[34:32], src_address[66:35],
    // dst_address[98:67], src_udp_port[114:99], dst_udp_port[130:115],
    // header_check[146:131], zero fill [151:147]
    input  logic [uce_pkg::S_TDATA_W-1:0]   i_s_axis_tdata,
    // tuser: mode
    input  logic                            i_s_axis_tuser,
    input  logic                            i_s_axis_tlast,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // tdata: checksum[15:0]
    output logic [uce_pkg::M_TDATA_W-1:0]   o_m_axis_tdata,
    // tuser: is_zero
    output logic                            o_m_axis_tuser
);

    // Packet tracking state, updated on every accepted request.
    logic                               r_start;
    logic                               r_mode;
    logic [uce_pkg::COUNT_W-1:0]        r_bytes;

    // Stage A: the lane registers plus their control.
    logic                               r_a_valid;
    uce_pkg::t_ctrl                     r_a_ctrl;

    logic                               accept;
    logic                               a_take;
    logic                               mode_eff;
    logic                               pseudo;
    logic [2:0]                         count;
    logic [31:0]                        keep;
    logic [31:0]                        data_masked;
    logic [uce_pkg::COUNT_W-1:0]        n_bytes;
    uce_pkg::t_half                     udp_len;
    uce_pkg::t_ctrl                     ctrl_in;

    logic [31:0]                        f_data;
    logic [2:0]                         f_count;
    logic [31:0]                        f_src_addr;
    logic [31:0]                        f_dst_addr;
    uce_pkg::t_half                     f_src_udp_port;
    uce_pkg::t_half                     f_dst_udp_port;
    uce_pkg::t_half                     f_hdr_ck;

    uce_pkg::t_half                     lane_a   [uce_pkg::LANES];
    uce_pkg::t_half                     lane_b   [uce_pkg::LANES];
    uce_pkg::t_half                     lane_sum [uce_pkg::LANES];

    // Unpack the request fields.
    assign f_data         = i_s_axis_tdata[uce_pkg::OFS_DATA         +: 32];
    assign f_count        = i_s_axis_tdata[uce_pkg::OFS_COUNT        +: 3];
    assign f_src_addr     = i_s_axis_tdata[uce_pkg::OFS_SRC_ADDR     +: 32];
    assign f_dst_addr     = i_s_axis_tdata[uce_pkg::OFS_DST_ADDR     +: 32];
    assign f_src_udp_port = i_s_axis_tdata[uce_pkg::OFS_SRC_UDP_PORT +: 16];
    assign f_dst_udp_port = i_s_axis_tdata[uce_pkg::OFS_DST_UDP_PORT +: 16];
    assign f_hdr_ck       = i_s_axis_tdata[uce_pkg::OFS_HDR_CK       +: 16];

    assign o_s_axis_tready = !r_a_valid || a_take;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // Mode is taken from the first word of a packet and held to its end.
    assign mode_eff = r_start ? i_s_axis_tuser : r_mode;
    // The pseudo-header addresses, protocol, ports and header field enter once.
    assign pseudo   = r_start && i_s_axis_tuser;

    // Clamp oversize byte counts to a full word.
    assign count = (f_count > uce_pkg::WORD_BYTES) ? uce_pkg::WORD_BYTES : f_count;

    // Zero the bytes past the count; the first byte sits in the top bits.
    always_comb begin
        case (count)
            3'd0:    keep = 32'h0000_0000;
            3'd1:    keep = 32'hff00_0000;
            3'd2:    keep = 32'hffff_0000;
            3'd3:    keep = 32'hffff_ff00;
            default: keep = 32'hffff_ffff;
        endcase
    end
    assign data_masked = f_data & keep;

    // Running byte count wraps at 17 bits; only its low half enters the length.
    assign n_bytes = (r_start ? '0 : r_bytes) + uce_pkg::COUNT_W'(count);
    assign udp_len = uce_pkg::UDP_HDR_BYTES + n_bytes[uce_pkg::HALF_W-1:0];

    // Feed the lanes; a lane with nothing to add this word sees zeros.
    always_comb begin
        lane_a[uce_pkg::LANE_SRC]   = pseudo ? f_src_addr[31:16] : '0;
        lane_b[uce_pkg::LANE_SRC]   = pseudo ? f_src_addr[15:0]  : '0;
        lane_a[uce_pkg::LANE_DST]   = pseudo ? f_dst_addr[31:16] : '0;
        lane_b[uce_pkg::LANE_DST]   = pseudo ? f_dst_addr[15:0]  : '0;
        lane_a[uce_pkg::LANE_PROTO] = pseudo ? uce_pkg::UDP_PROTOCOL : '0;
        lane_b[uce_pkg::LANE_PROTO] = pseudo ? f_hdr_ck   : '0;
        lane_a[uce_pkg::LANE_PORTS] = pseudo ? f_src_udp_port : '0;
        lane_b[uce_pkg::LANE_PORTS] = pseudo ? f_dst_udp_port : '0;
        lane_a[uce_pkg::LANE_DATA]  = data_masked[31:16];
        lane_b[uce_pkg::LANE_DATA]  = data_masked[15:0];
        lane_a[uce_pkg::LANE_LEN]   = (mode_eff && i_s_axis_tlast) ? udp_len : '0;
        lane_b[uce_pkg::LANE_LEN]   = (mode_eff && i_s_axis_tlast) ? udp_len : '0;
    end

    for (genvar g = 0; g < uce_pkg::LANES; g++) begin : g_lane
        uce_lane u_lane (
            .i_clk (i_clk),
            .i_en  (accept),
            .i_a   (lane_a[g]),
            .i_b   (lane_b[g]),
            .o_sum (lane_sum[g])
        );
    end

    assign ctrl_in.last  = i_s_axis_tlast;
    assign ctrl_in.start = r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start   <= 1'b1;
            r_mode    <= 1'b0;
            r_bytes   <= '0;
            r_a_valid <= 1'b0;
            r_a_ctrl  <= '0;
        end else begin
            if (accept) begin
                r_start   <= i_s_axis_tlast;
                r_mode    <= mode_eff;
                r_bytes   <= n_bytes;
                r_a_valid <= 1'b1;
                r_a_ctrl  <= ctrl_in;
            end else if (a_take) begin
                r_a_valid <= 1'b0;
            end
        end
    end

    // Merge the lane partials, fold them into the packet sum, hold the result.
    uce_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_a_valid  (r_a_valid),
        .i_a_ctrl   (r_a_ctrl),
        .i_part     (lane_sum),
        .o_a_take   (a_take),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_checksum (o_m_axis_tdata),
        .o_is_zero  (o_m_axis_tuser)
    );

endmodule

[hw/rtl/uce_sva.sv]
module uce_sva (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    input  logic [uce_pkg::M_TDATA_W-1:0] o_m_axis_tdata,
    input  logic                          o_m_axis_tuser
);

    // Hold a stalled result request.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("stalled result changed");

    // The verify flag must agree with the checksum it travels with.
    a_zero_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tuser == (o_m_axis_tdata == '0)))
        else $error("zero flag disagrees with checksum");

    // No result straight out of reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind udp_ipv4_checksum_engine uce_sva u_uce_sva (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

[tb/sv/tb_udp_ipv4_checksum_engine.sv]
module tb_udp_ipv4_checksum_engine;
    timeunit 1ns;
    timeprecision 1ps;

    // Run sizing. The long packet streams back to back well past the others.
    localparam int RANDOM_WORDS = 600;
    localparam int LONG_WORDS   = 64;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 12;

    // One input request: a packet word plus the header fields riding beside it.
    typedef struct packed {
        logic        mode;
        logic [31:0] data;
        logic [2:0]  nbytes;
        logic        last;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [15:0] src_udp_port;
        logic [15:0] dst_udp_port;
        logic [15:0] hdr_ck;
    } t_word_req;

    // One result: folded checksum and its zero flag.
    typedef struct packed {
        logic [15:0] ck;
        logic        zero;
    } t_sum_res;

    // Directed vector: a request and, where obvious, the checksum it must give.
    typedef struct packed {
        t_word_req w;
        logic      typed;
        t_sum_res  want;
    } t_vector;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_s_axis_tvalid = 1'b0;
    logic                           o_s_axis_tready;
    // tdata from bit 0: data_word, byte_count, src_address, dst_address,
    // src_udp_port, dst_udp_port, header_check, zero fill
    logic [uce_pkg::S_TDATA_W-1:0]  i_s_axis_tdata = '0;
    // tuser: mode
    logic                           i_s_axis_tuser = 1'b0;
    logic                           i_s_axis_tlast = 1'b0;
    logic                           o_m_axis_tvalid;
    logic                           i_m_axis_tready = 1'b0;
    // tdata: checksum
    logic [uce_pkg::M_TDATA_W-1:0]  o_m_axis_tdata;
    // tuser: is_zero
    logic                           o_m_axis_tuser;

    udp_ipv4_checksum_engine uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    // Checksum predictor state, mirrors the engine's accumulator after reset.
    logic [15:0] acc_sum    = '0;
    logic [16:0] byte_total = '0;
    logic        pkt_start  = 1'b1;
    logic        pkt_mode   = 1'b0;

    t_sum_res    pending_sums[$];   // checksums predicted but not yet seen
    t_sum_res    last_sum;          // most recent prediction, used for verify copies
    t_vector     vectors[$];

    int          errors     = 0;
    int          cycles     = 0;
    int          n_words    = 0;
    int          n_udp      = 0;
    int          n_checked  = 0;
    int          n_zero     = 0;
    int          calm_left  = 0;
    int          stall_left = 0;
    bit          no_gaps    = 1'b0;

    // Add a 16-bit half with end-around carry.
    function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s > 17'h0ffff)
            s = s - 17'h0ffff;
        return s[15:0];
    endfunction

    // Advance the predictor by one accepted word; flag a result on the last word.
    task automatic predict_word(input t_word_req w, output bit produced, output t_sum_res r);
        logic [2:0]  n;
        logic [31:0] keep;
        logic [31:0] masked;
        logic [15:0] udp_len;
        produced = 1'b0;
        r = '0;
        if (pkt_start) begin
            acc_sum    = '0;
            byte_total = '0;
            pkt_mode   = w.mode;
            pkt_start  = 1'b0;
            if (pkt_mode) begin
                // Fold the pseudo-header and the fixed UDP header fields.
                acc_sum = ones_add(acc_sum, w.src_ip[31:16]);
                acc_sum = ones_add(acc_sum, w.src_ip[15:0]);
                acc_sum = ones_add(acc_sum, w.dst_ip[31:16]);
                acc_sum = ones_add(acc_sum, w.dst_ip[15:0]);
                acc_sum = ones_add(acc_sum, uce_pkg::UDP_PROTOCOL);
                acc_sum = ones_add(acc_sum, w.src_udp_port);
                acc_sum = ones_add(acc_sum, w.dst_udp_port);
                acc_sum = ones_add(acc_sum, w.hdr_ck);
            end
        end
        // Clamp oversize counts, zero the missing tail bytes.
        n      = (w.nbytes > 3'd4) ? 3'd4 : w.nbytes;
        keep   = (n == 3'd0) ? 32'h0 : (32'hffff_ffff << (8 * (4 - int'(n))));
        masked = w.data & keep;
        acc_sum    = ones_add(acc_sum, masked[31:16]);
        acc_sum    = ones_add(acc_sum, masked[15:0]);
        byte_total = byte_total + 17'(n);
        if (w.last) begin
            if (pkt_mode) begin
                udp_len = uce_pkg::UDP_HDR_BYTES + byte_total[15:0];
                acc_sum = ones_add(acc_sum, udp_len);
                acc_sum = ones_add(acc_sum, udp_len);
            end
            r.ck      = ~acc_sum;
            r.zero    = (r.ck == 16'h0);
            produced  = 1'b1;
            pkt_start = 1'b1;
        end
    endtask

    // Sender idle length: mostly short, now and then long.
    function automatic int idle_span();
        if ($urandom_range(0, 99) < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Fill a word with random header fields; only the first word's are used.
    function automatic t_word_req rand_word(input logic mode, input int nb, input logic lst);
        t_word_req w;
        w.mode         = mode;
        w.data         = $urandom();
        w.nbytes       = 3'(nb);
        w.last         = lst;
        w.src_ip       = $urandom();
        w.dst_ip       = $urandom();
        w.src_udp_port = 16'($urandom_range(0, 65535));
        w.dst_udp_port = 16'($urandom_range(0, 65535));
        w.hdr_ck       = 16'($urandom_range(0, 65535));
        return w;
    endfunction

    // Queue one directed vector.
    function automatic void vec(input logic m, input logic [31:0] d, input int nb,
                                input logic lst, input logic [31:0] sa, input logic [31:0] da,
                                input logic [15:0] sp, input logic [15:0] dp,
                                input logic [15:0] hc, input logic typed,
                                input logic [15:0] ck, input logic z);
        t_vector v;
        v.w       = '{mode: m, data: d, nbytes: 3'(nb), last: lst, src_ip: sa,
                      dst_ip: da, src_udp_port: sp, dst_udp_port: dp, hdr_ck: hc};
        v.typed   = typed;
        v.want.ck = ck;
        v.want.zero = z;
        vectors.push_back(v);
    endfunction

    // Present one request, hold it until accepted, then log the expected checksum of a last word.
    task automatic send_word(input t_word_req w, input logic typed, input t_sum_res want);
        int                             gap;
        bit                             got;
        t_sum_res                       r;
        logic [uce_pkg::S_TDATA_W-1:0]  td;
        gap = no_gaps ? 0 : (($urandom_range(0, 99) < 50) ? 0 : idle_span());
        if (gap > 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        td = '0;
        td[uce_pkg::OFS_DATA         +: 32] = w.data;
        td[uce_pkg::OFS_COUNT        +: 3]  = w.nbytes;
        td[uce_pkg::OFS_SRC_ADDR     +: 32] = w.src_ip;
        td[uce_pkg::OFS_DST_ADDR     +: 32] = w.dst_ip;
        td[uce_pkg::OFS_SRC_UDP_PORT +: 16] = w.src_udp_port;
        td[uce_pkg::OFS_DST_UDP_PORT +: 16] = w.dst_udp_port;
        td[uce_pkg::OFS_HDR_CK       +: 16] = w.hdr_ck;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= td;
        i_s_axis_tuser  <= w.mode;
        i_s_axis_tlast  <= w.last;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        if (pkt_start && w.mode)
            n_udp++;
        predict_word(w, got, r);
        n_words++;
        if (got) begin
            last_sum = typed ? want : r;
            pending_sums.push_back(last_sum);
        end
    endtask

    // Output side: random stalls, some long, with calm stretches of steady ready.
    always @(posedge i_clk) begin
        int r;
        if (calm_left > 0) begin
            calm_left--;
            i_m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 5)
                calm_left = $urandom_range(10, 60);
            else if (r < 35)
                stall_left = idle_span();
            i_m_axis_tready <= 1'b1;
        end
    end

    // Compare each accepted checksum with the oldest expectation.
    always @(posedge i_clk) begin
        t_sum_res exp_sum;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected checksum %h is_zero %b", $time,
                         o_m_axis_tdata, o_m_axis_tuser);
                errors++;
            end else begin
                exp_sum = pending_sums.pop_front();
                n_checked++;
                if (o_m_axis_tuser)
                    n_zero++;
                if (o_m_axis_tdata !== exp_sum.ck) begin
                    $display("%0t: checksum expected %h actual %h", $time,
                             exp_sum.ck, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tuser !== exp_sum.zero) begin
                    $display("%0t: is_zero expected %b actual %b", $time,
                             exp_sum.zero, o_m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles, %0d checksums outstanding", $time,
                     cycles, pending_sums.size());
            $display("FAIL udp_ipv4_checksum_engine");
            $finish;
        end
    end

    initial begin
        t_word_req  w;
        t_word_req  pkt[$];
        t_sum_res   none;
        int         rand_words;
        int         len;
        int         pick;
        logic       mode;

        none = '0;

        // Directed vectors. Typed expectations only where they are obvious.
        // All-zero data: sum stays empty, checksum is all ones.
        vec(0, 32'h0000_0000, 4, 1, 0, 0, 0, 0, 0, 1, 16'hffff, 0);
        // All-ones data: sum folds to all ones, checksum zero.
        vec(0, 32'hffff_ffff, 4, 1, 0, 0, 0, 0, 0, 1, 16'h0000, 1);
        // Byte count zero: data ignored entirely.
        vec(0, 32'hffff_ffff, 0, 1, 0, 0, 0, 0, 0, 1, 16'hffff, 0);
        // Byte count above four behaves as four.
        vec(0, 32'h1234_5678, 7, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        // Short word in mid-packet; packet continues.
        vec(0, 32'ha5a5_a5a5, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        vec(0, 32'h89ab_cdef, 2, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        vec(0, 32'hfedc_ba98, 3, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        // UDP packet; mode on the second word must be ignored.
        vec(1, 32'h0102_0304, 4, 0, 32'hc0a8_0001, 32'hc0a8_0002, 16'h1234, 16'h0035,
            16'h0000, 0, 0, 0);
        vec(0, 32'h0506_0708, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        // UDP with every header field at its maximum.
        vec(1, 32'hffff_ffff, 4, 1, 32'hffff_ffff, 32'hffff_ffff, 16'hffff, 16'hffff,
            16'hffff, 0, 0, 0);
        // UDP with nothing but the protocol and the length.
        vec(1, 32'h0000_0000, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        // Plain packet whose later word asks for UDP; addresses must be ignored.
        vec(0, 32'h1111_1111, 4, 0, 32'hdead_beef, 32'h0bad_f00d, 16'h5555, 16'haaaa,
            16'h7777, 0, 0, 0);
        vec(1, 32'h2222_2222, 5, 0, 32'h1357_9bdf, 32'h2468_ace0, 16'h0101, 16'h0202,
            16'h0303, 0, 0, 0);
        vec(1, 32'h3333_3333, 6, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        // Carry-heavy UDP fields.
        vec(1, 32'h8000_0001, 4, 0, 32'h8000_0000, 32'h0000_0001, 16'h8000, 16'h0001,
            16'h8000, 0, 0, 0);
        vec(1, 32'h7fff_ffff, 2, 1, 0, 0, 0, 0, 0, 0, 0, 0);
        // Zero-count word in mid-packet.
        vec(0, 32'h0000_ffff, 4, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        vec(0, 32'hffff_0000, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        vec(0, 32'h0001_0000, 4, 1, 0, 0, 0, 0, 0, 0, 0, 0);

        // Hold reset once, at the start of the run.
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (vectors[i])
            send_word(vectors[i].w, vectors[i].typed, vectors[i].want);

        // One long UDP packet, back to back.
        no_gaps = 1'b1;
        for (int i = 0; i < LONG_WORDS; i++) begin
            w = rand_word((i == 0) ? 1'b1 : 1'($urandom_range(0, 1)), 4, i == LONG_WORDS - 1);
            send_word(w, 1'b0, none);
        end

        // Random packets: mostly well formed, some noise with odd byte counts.
        rand_words = 0;
        while (rand_words < RANDOM_WORDS) begin
            no_gaps = ($urandom_range(0, 99) < 20);
            pick    = $urandom_range(0, 99);
            mode    = 1'($urandom_range(0, 1));
            pkt.delete();
            if (pick < 85) begin
                len = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 8)
                                                   : $urandom_range(9, 40);
                for (int i = 0; i < len; i++) begin
                    w = rand_word((i == 0) ? mode : 1'($urandom_range(0, 1)),
                                  (i == len - 1) ? $urandom_range(0, 4) : 4, i == len - 1);
                    if (i == 0 && mode && $urandom_range(0, 99) < 30)
                        w.hdr_ck = '0;
                    pkt.push_back(w);
                    send_word(w, 1'b0, none);
                end
                rand_words += len;
                // Now and then resend a UDP packet carrying its own checksum: verify case.
                if (mode && $urandom_range(0, 99) < 25) begin
                    foreach (pkt[i]) begin
                        w = pkt[i];
                        if (i == 0)
                            w.hdr_ck = last_sum.ck;
                        send_word(w, 1'b0, none);
                    end
                    rand_words += pkt.size();
                end
            end else begin
                len = $urandom_range(1, 6);
                for (int i = 0; i < len; i++) begin
                    w = rand_word((i == 0) ? mode : 1'($urandom_range(0, 1)),
                                  $urandom_range(0, 7), i == len - 1);
                    send_word(w, 1'b0, none);
                end
                rand_words += len;
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain: wait for every predicted checksum, then watch for strays.
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d words in %0d packets, %0d with the UDP pseudo-header,", n_words,
                 n_checked, n_udp);
        $display("including one %0d-word packet; %0d checksums came out zero.", LONG_WORDS,
                 n_zero);
        if (errors == 0)
            $display("PASS udp_ipv4_checksum_engine");
        else
            $display("FAIL udp_ipv4_checksum_engine");
        $finish;
    end

endmodule
